/* rtl/swm_pkg.sv */
`default_nettype none

package swm_pkg;

    localparam int WIN_BITS = 7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/swm_front.sv */
`default_nettype none

module swm_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int CW          = $clog2(MAX_WINDOW + 1),
    parameter int QW          = SAMPLE_BITS + 1 + CW
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           window_size_we,
    input  wire logic [swm_pkg::WIN_BITS-1:0]   window_size,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic                           start_of_stream,
    output logic                                push,
    output logic [QW-1:0]                       push_data,
    input  wire logic                           q_full
);
    import swm_pkg::*;

    localparam int EW = (CW > WIN_BITS) ? CW : WIN_BITS;

    logic [WIN_BITS-1:0] window_size_reg;
    logic [CW-1:0]       fill_count_reg;
    logic [CW-1:0]       fill_count_next;
    logic [CW-1:0]       fill_base;
    logic [EW-1:0]       win_ext;
    logic [CW-1:0]       win_eff;
    logic                emit;
    logic [CW-1:0]       scan_len;

    assign sample_stall = q_full;
    assign push         = sample_valid && !q_full;

    // clamp window into 1..MAX_WINDOW
    always_comb
    begin
        win_ext = EW'(window_size_reg);
        if (win_ext == EW'(0))
            win_ext = EW'(1);
        if (win_ext > EW'(MAX_WINDOW))
            win_ext = EW'(MAX_WINDOW);
        win_eff = win_ext[CW-1:0];
    end

    always_comb
    begin
        fill_base = start_of_stream ? CW'(0) : fill_count_reg;
        if (fill_base < CW'(MAX_WINDOW))
            fill_count_next = fill_base + CW'(1);
        else
            fill_count_next = fill_base;
        emit     = (fill_count_next >= win_eff);
        scan_len = emit ? (win_eff - CW'(1)) : CW'(0);
    end

    assign push_data = {sample, emit, scan_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_BITS'(1);
            fill_count_reg  <= '0;
        end
        else
        begin
            if (window_size_we)
                window_size_reg <= window_size;
            if (push)
                fill_count_reg <= fill_count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/swm_queue.sv */
`default_nettype none

module swm_queue #(
    parameter int QW = 40
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [QW-1:0] push_data,
    input  wire logic          pop,
    output logic [QW-1:0]      pop_data,
    output logic               q_valid,
    output logic               q_full
);
    import swm_pkg::*;

    logic [QW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign q_valid  = (count_reg != 2'd0);
    assign q_full   = (count_reg == 2'd2);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

/* rtl/swm_back.sv */
`default_nettype none

module swm_back #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int CW          = $clog2(MAX_WINDOW + 1),
    parameter int QW          = SAMPLE_BITS + 1 + CW
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire logic [QW-1:0]          pop_data,
    output logic                        pop,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic signed [SAMPLE_BITS-1:0] window_max
);
    import swm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    back_state_t                   state_reg, state_next;
    logic [AW-1:0]                 slot_reg, slot_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [CW-1:0]                 left_reg, left_next;
    logic                          pend_reg, pend_next;
    logic signed [SAMPLE_BITS-1:0] best_reg, best_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_emit;
    logic [CW-1:0]                 q_scan;
    logic                          wr_en;
    logic                          rd_en;
    logic                          out_take;

    assign q_sample = pop_data[QW-1 -: SAMPLE_BITS];
    assign q_emit   = pop_data[CW];
    assign q_scan   = pop_data[CW-1:0];

    assign out_take     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign window_max   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        best_next      = best_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    wr_en     = 1'b1;
                    best_next = q_sample;
                    ptr_next  = (slot_reg == '0) ? LAST_SLOT : slot_reg - AW'(1);
                    slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                    left_next = q_scan;
                    if (q_scan != '0)
                        state_next = ST_SCAN;
                    else if (q_emit)
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    ptr_next  = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - AW'(1);
                    left_next = left_reg - CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
                if (pend_reg && (rd_data_reg > best_reg))
                    best_next = rd_data_reg;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring of recent words
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[slot_reg] <= q_sample;
        if (rd_en)
            rd_data_reg <= ring_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        best_reg     <= best_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("word taken from queue outside idle");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("ring read data pending outside scan");

    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (q_scan != '0)) |=> (state_reg == ST_SCAN) && (left_reg != '0))
        else $error("scan not started for a multi-word window");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (left_reg <= CW'(MAX_WINDOW - 1)))
        else $error("scan length beyond ring depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && result_stall)
            |=> (state_reg == ST_DONE) && $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

/* rtl/sliding_window_maximum.sv */
// sliding window maximum of a signed sample stream
//
// input channel: sample and start_of_stream with sample_valid / sample_stall;
// a word is taken at a clock edge with sample_valid high and sample_stall low.
// output channel: window_max with result_valid / result_stall, same rule.
// the user must write window_size through window_size_we only while the
// block is idle; the block itself does not enforce this. each word gives one
// result once the window holds window_size words of the current stream;
// start_of_stream empties the window before its word is kept. the front
// keeps the fill count and tags each word; a two-word queue feeds the back,
// which keeps the ring and scans it with one read port and one comparator,
// one older word a cycle. the back takes a word only in idle and writes it
// to the ring; for a result over a window of w it then scans the w - 1 older
// words and hands the result out in done before the next word. reset empties
// the queue and the window and sets window_size to 1; ring contents are not
// cleared. while result_stall is high the result is held, the back waits in
// done with its next result and the queue takes words until it is full.
`default_nettype none

module sliding_window_maximum #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           window_size_we,
    input  wire logic [swm_pkg::WIN_BITS-1:0]   window_size,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic                           start_of_stream,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic signed [SAMPLE_BITS-1:0]       window_max
);
    import swm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int QW = SAMPLE_BITS + 1 + CW;

    logic          push;
    logic [QW-1:0] push_data;
    logic          pop;
    logic [QW-1:0] pop_data;
    logic          q_valid;
    logic          q_full;

    swm_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .QW          (QW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_size_we  (window_size_we),
        .window_size     (window_size),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .push            (push),
        .push_data       (push_data),
        .q_full          (q_full)
    );

    swm_queue #(
        .QW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_valid   (q_valid),
        .q_full    (q_full)
    );

    swm_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .QW          (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_max   (window_max)
    );

endmodule

`default_nettype wire
